>>> sv/lkvc_pkg.sv
package lkvc_pkg;

  localparam int unsigned LKVC_MAX_ENTRIES = 16;
  localparam int unsigned CAP_WIDTH = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

endpackage

>>> sv/lkvc_store.sv
module lkvc_store #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::LKVC_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lkvc_pkg::CAP_WIDTH-1:0] capacity,
  input  logic                          commit,
  input  lkvc_pkg::req_t                req,
  output lkvc_pkg::rsp_t                rsp
);
  import lkvc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

  logic [MAX_ENTRIES-1:0] entry_valid, valid_next;
  logic signed [31:0]     entry_key   [MAX_ENTRIES];
  logic signed [31:0]     entry_value [MAX_ENTRIES];
  logic [AW-1:0]          entry_age   [MAX_ENTRIES];
  logic [AW-1:0]          age_next    [MAX_ENTRIES];
  logic [CW-1:0]          entry_count, count_next;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] victim;
  logic [MAX_ENTRIES-1:0] kept;
  logic [MAX_ENTRIES-1:0] free_slot;
  logic [MAX_ENTRIES-1:0] key_we;
  logic [MAX_ENTRIES-1:0] value_we;
  logic                   hit;
  logic                   evict;
  logic signed [31:0]     found_value;
  logic signed [31:0]     victim_key;
  logic [AW-1:0]          found_age;
  logic [AW-1:0]          oldest_age;
  logic [EW-1:0]          eff_cap;
  logic [EW-1:0]          count_ext;

  // Valid keys are distinct, so at most one entry matches.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_key[i] == req.key);
    end
  end

  assign hit = |match;

  always_comb begin
    found_value = '0;
    found_age   = '0;
    victim_key  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        found_value = found_value | entry_value[i];
        found_age   = found_age | entry_age[i];
      end
      if (victim[i]) begin
        victim_key = victim_key | entry_key[i];
      end
    end
  end

  // Capacity of zero behaves as one, anything above the store size as the store size.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(capacity) > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = EW'(capacity);
    end
  end

  assign count_ext  = EW'(entry_count);
  assign oldest_age = AW'(entry_count - CW'(1));

  // Ranks of valid entries are always 0..count-1, so the least recent entry is
  // the one whose rank equals count-1.
  always_comb begin
    evict = (req.operation == OP_PUT) && !hit && (count_ext >= eff_cap)
            && (entry_count != '0);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim[i] = evict && entry_valid[i] && (entry_age[i] == oldest_age);
    end
    kept      = entry_valid & ~victim;
    free_slot = ~kept & (kept + MAX_ENTRIES'(1));
  end

  always_comb begin
    valid_next = entry_valid;
    count_next = entry_count;
    key_we     = '0;
    value_we   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_next[i] = entry_age[i];
    end
    if (req.operation == OP_PUT && !hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (kept[i]) begin
          age_next[i] = entry_age[i] + AW'(1);
        end
        if (free_slot[i]) begin
          age_next[i] = '0;
        end
      end
      valid_next = kept | free_slot;
      key_we     = free_slot;
      value_we   = free_slot;
      count_next = evict ? entry_count : entry_count + CW'(1);
    end else if (hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (entry_valid[i] && !match[i] && (entry_age[i] < found_age)) begin
          age_next[i] = entry_age[i] + AW'(1);
        end
        if (match[i]) begin
          age_next[i] = '0;
        end
      end
      if (req.operation == OP_PUT) begin
        value_we = match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else if (commit) begin
      entry_valid <= valid_next;
      entry_count <= count_next;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_age[i] <= age_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (commit && key_we[i]) begin
        entry_key[i] <= req.key;
      end
      if (commit && value_we[i]) begin
        entry_value[i] <= req.value;
      end
    end
  end

  always_comb begin
    rsp.hit         = hit;
    rsp.evicted     = evict;
    rsp.evicted_key = victim_key;
    if (req.operation == OP_GET) begin
      rsp.read_value = hit ? found_value : READ_MISS;
    end else begin
      rsp.read_value = '0;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("entry count disagrees with valid entries");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= MAX_ENTRIES)
    else $error("entry count above store size");

  a_evict_single: assert property (@(posedge clk) disable iff (rst)
    evict |-> $onehot(victim))
    else $error("eviction without exactly one least recent entry");

endmodule

>>> sv/lru_key_value_cache.sv
// LRU key-value cache, fully associative.
// Requests arrive on req (req_valid/req_stall) as a get or a put of a 32-bit key
// and value; each request yields exactly one response on rsp (rsp_valid/rsp_stall)
// carrying the hit flag, the read value, and the key of any evicted entry.
// A transaction is taken on a clock edge where valid is high and stall is low.
// The request is registered in req_q, looked up against all entries in parallel
// from that register, and its response is registered in the response register.
// One request per cycle is sustained while rsp_stall is low; the combinational
// lookup and recency update allow that rate.
// When the receiver holds rsp_stall, the response register holds its value and
// the request register fills, after which req_stall is raised.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data
// (always ready) and should be changed only while the cache is idle.
// Synchronous reset empties the store, sets capacity to 16 and clears both
// valid flags; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::LKVC_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  lkvc_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output lkvc_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkvc_pkg::CAP_WIDTH-1:0] cfg_data
);
  import lkvc_pkg::*;

  logic [CAP_WIDTH-1:0] capacity;
  req_t                 req_q;
  logic                 req_q_valid;
  logic                 rsp_free;
  logic                 process;
  rsp_t                 rsp_next;

  assign cfg_ready = 1'b1;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign process   = req_q_valid && rsp_free;
  assign req_stall = req_q_valid && !rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  lkvc_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .capacity(capacity),
    .commit  (process),
    .req     (req_q),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= process;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import lkvc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;
  localparam int NO_CAP = -1;
  localparam int RANDOM_CAP = 99;
  localparam int POOL_MAX = 24;
  localparam int AGE_W = $clog2(LKVC_MAX_ENTRIES);
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ALL_ONES = 32'shFFFF_FFFF;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_WIDTH-1:0] cfg_data = '0;

  lru_key_value_cache u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Mirror of the cache contents used to predict each response.
  logic                 slot_used  [LKVC_MAX_ENTRIES];
  logic signed [31:0]   slot_key   [LKVC_MAX_ENTRIES];
  logic signed [31:0]   slot_value [LKVC_MAX_ENTRIES];
  logic [AGE_W-1:0]     slot_age   [LKVC_MAX_ENTRIES];
  int unsigned          used_count = 0;
  logic [CAP_WIDTH-1:0] capacity_reg = CAP_RESET;

  rsp_t        expected_rsp_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  typedef struct {
    int                 cap;
    op_t                op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    bit                 known;
    rsp_t               rsp;
  } dir_row_t;

  typedef struct {
    int cap;
    int send_idle;
    int stall;
    int items;
    bit squeeze;
  } phase_t;

  dir_row_t dir_rows [20] = '{
    '{NO_CAP, OP_GET, 32'sd0,    32'sd0,    1'b1, '{1'b0, READ_MISS, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, KEY_MIN,   KEY_MAX,   1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, KEY_MAX,   KEY_MIN,   1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_GET, KEY_MIN,   32'sd7,    1'b1, '{1'b1, KEY_MAX, 1'b0, 32'sd0}},
    '{NO_CAP, OP_GET, KEY_MAX,   32'sd0,    1'b1, '{1'b1, KEY_MIN, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, KEY_MAX,   32'sd0,    1'b1, '{1'b1, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_GET, KEY_MAX,   ALL_ONES,  1'b1, '{1'b1, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, ALL_ONES,  ALL_ONES,  1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
    // A hit whose stored value looks exactly like the miss marker.
    '{NO_CAP, OP_GET, ALL_ONES,  32'sd0,    1'b1, '{1'b1, ALL_ONES, 1'b0, 32'sd0}},
    '{NO_CAP, OP_GET, 32'sd0,    32'sd0,    1'b1, '{1'b0, READ_MISS, 1'b0, 32'sd0}},
    // Capacity drops below the entry count: every insert now evicts one.
    '{2,      OP_PUT, 32'sd5,    32'sd55,   1'b1, '{1'b0, 32'sd0, 1'b1, KEY_MIN}},
    '{NO_CAP, OP_GET, KEY_MAX,   32'sd0,    1'b1, '{1'b1, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, 32'sd6,    32'sd66,   1'b1, '{1'b0, 32'sd0, 1'b1, ALL_ONES}},
    '{NO_CAP, OP_PUT, 32'sd7,    32'sd77,   1'b1, '{1'b0, 32'sd0, 1'b1, 32'sd5}},
    // Zero capacity behaves like one.
    '{0,      OP_PUT, 32'sd8,    32'sd88,   1'b1, '{1'b0, 32'sd0, 1'b1, KEY_MAX}},
    '{NO_CAP, OP_GET, 32'sd6,    32'sd0,    1'b0, '0},
    // Capacity above the entry limit is clamped to the limit.
    '{31,     OP_PUT, 32'sd9,    32'sd99,   1'b1, '{1'b0, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_PUT, 32'sd9,    32'sd1,    1'b1, '{1'b1, 32'sd0, 1'b0, 32'sd0}},
    '{NO_CAP, OP_GET, 32'sd9,    32'sd0,    1'b0, '0},
    '{NO_CAP, OP_GET, 32'sh55AA55AA, 32'sd0, 1'b1, '{1'b0, READ_MISS, 1'b0, 32'sd0}}
  };

  phase_t phases [8] = '{
    '{16,         0,  0,  200, 1'b0},
    '{1,          83, 0,  150, 1'b0},
    '{0,          0,  83, 150, 1'b0},
    '{31,         33, 33, 200, 1'b0},
    '{3,          0,  0,  150, 1'b1},
    '{8,          83, 0,  150, 1'b0},
    '{RANDOM_CAP, 0,  83, 150, 1'b0},
    '{2,          33, 33, 150, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lru_key_value_cache verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response transaction with no request outstanding");
        mismatches++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
          mismatches++;
        end
        if (rsp.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
          mismatches++;
        end
        if (rsp.evicted !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
          mismatches++;
        end
        if (rsp.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %0d, got %0d", want.evicted_key, rsp.evicted_key);
          mismatches++;
        end
      end
    end
  end

  // Applies one access to the mirror and returns the response it must produce.
  function automatic rsp_t lru_access(input req_t r);
    rsp_t             o;
    int               i;
    int               found;
    int               oldest;
    int               free_slot;
    int unsigned      eff_cap;
    logic [AGE_W-1:0] rank;
    o = '0;
    found = -1;
    for (i = 0; i < LKVC_MAX_ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == r.key)
        found = i;
    if (found >= 0) begin
      o.hit = 1'b1;
      if (r.operation == OP_GET)
        o.read_value = slot_value[found];
      else
        slot_value[found] = r.value;
      rank = slot_age[found];
      for (i = 0; i < LKVC_MAX_ENTRIES; i++)
        if (slot_used[i] && i != found && slot_age[i] < rank)
          slot_age[i]++;
      slot_age[found] = '0;
    end else if (r.operation == OP_GET) begin
      o.read_value = READ_MISS;
    end else begin
      eff_cap = (capacity_reg == 0) ? 1 :
                (capacity_reg > LKVC_MAX_ENTRIES) ? LKVC_MAX_ENTRIES : capacity_reg;
      if (used_count + 1 > eff_cap && used_count > 0) begin
        oldest = -1;
        for (i = 0; i < LKVC_MAX_ENTRIES; i++)
          if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
            oldest = i;
        o.evicted = 1'b1;
        o.evicted_key = slot_key[oldest];
        slot_used[oldest] = 1'b0;
        used_count--;
      end
      free_slot = -1;
      for (i = 0; i < LKVC_MAX_ENTRIES; i++) begin
        if (slot_used[i])
          slot_age[i]++;
        else if (free_slot < 0)
          free_slot = i;
      end
      slot_used[free_slot] = 1'b1;
      slot_key[free_slot] = r.key;
      slot_value[free_slot] = r.value;
      slot_age[free_slot] = '0;
      used_count++;
    end
    return o;
  endfunction

  // Offers one request, holding it steady until it is taken, then predicts it.
  task automatic send_req(input req_t r, output rsp_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    predicted = lru_access(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_WIDTH-1:0] c);
    cfg_data <= c;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_reg = c;
  endtask

  initial begin : stimulus
    logic signed [31:0] key_pool [POOL_MAX];
    req_t               r;
    rsp_t               p;
    int                 pool_n;
    int unsigned        eff_cap;
    int                 ph;
    int                 n;
    for (int i = 0; i < LKVC_MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_age[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].cap != NO_CAP) begin
        drain();
        set_capacity(dir_rows[k].cap[CAP_WIDTH-1:0]);
      end
      r.operation = dir_rows[k].op;
      r.key = dir_rows[k].key;
      r.value = dir_rows[k].value;
      send_req(r, p);
      expected_rsp_q.push_back(dir_rows[k].known ? dir_rows[k].rsp : p);
    end

    for (ph = 0; ph < 8; ph++) begin
      drain();
      if (phases[ph].cap == RANDOM_CAP)
        set_capacity(CAP_WIDTH'($urandom_range(31)));
      else
        set_capacity(phases[ph].cap[CAP_WIDTH-1:0]);
      send_idle_pct = phases[ph].send_idle;
      stall_pct <= phases[ph].stall;
      eff_cap = (capacity_reg == 0) ? 1 :
                (capacity_reg > LKVC_MAX_ENTRIES) ? LKVC_MAX_ENTRIES : capacity_reg;
      // A pool slightly larger than the capacity gives a mix of hits, misses
      // and evictions.
      pool_n = (eff_cap + 4 > POOL_MAX) ? POOL_MAX : eff_cap + 4;
      foreach (key_pool[k])
        key_pool[k] = $urandom;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      for (n = 0; n < phases[ph].items; n++) begin
        if (phases[ph].squeeze && n == 30)
          holds_asked <= holds_asked + 1;
        r.operation = op_t'($urandom_range(1));
        r.key = ($urandom_range(99) < 10) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
        r.value = $urandom;
        send_req(r, p);
        expected_rsp_q.push_back(p);
      end
    end

    drain();
    if (mismatches == 0 && expected_rsp_q.size() == 0)
      $display("lru_key_value_cache verification clean");
    else
      $display("lru_key_value_cache verification failed");
    $finish;
  end

endmodule
